### hw/rtl/mcit_pkg.sv
package mcit_pkg;

  // Table size and derived index width
  localparam int NUM_TIMERS = 16;
  localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  // Field widths
  localparam int OP_W       = 4;
  localparam int ID_W       = 8;
  localparam int TIME_W     = 32;
  localparam int LIM_W      = 8;
  localparam int CNT_W      = 9;
  localparam int FID_W      = 4;
  localparam int KIND_W     = 2;
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 48;

  // Operation codes
  localparam logic [OP_W-1:0] OP_TICK        = 4'd0;
  localparam logic [OP_W-1:0] OP_ARM         = 4'd1;
  localparam logic [OP_W-1:0] OP_SET_IVL     = 4'd2;
  localparam logic [OP_W-1:0] OP_CLEAR       = 4'd3;
  localparam logic [OP_W-1:0] OP_CLEAR_ALL   = 4'd4;
  localparam logic [OP_W-1:0] OP_RESTART     = 4'd5;
  localparam logic [OP_W-1:0] OP_RESTART_ALL = 4'd6;
  localparam logic [OP_W-1:0] OP_PAUSE       = 4'd7;
  localparam logic [OP_W-1:0] OP_PAUSE_ALL   = 4'd8;

  // Result kinds
  localparam logic [KIND_W-1:0] EV_STATUS = 2'd0;
  localparam logic [KIND_W-1:0] EV_FIRE   = 2'd1;
  localparam logic [KIND_W-1:0] EV_DONE   = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic             accept;       // input beat taken this cycle
    logic             fire_filter;  // filter entry due: snap and report
    logic             catch_start;  // catch-up entry due: first advance
    logic             catch_step;   // one more catch-up advance
    logic             catch_fire;   // write back catch-up time and report
    logic             done;         // report end of tick
    logic [IDX_W-1:0] idx;          // entry under walk
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_tick;   // pending input beat is a tick
    logic due;       // walked entry is active, running and due
    logic filter;    // walked entry is in filter mode
    logic more;      // catch-up may fire again
    logic out_free;  // output register can take a beat
  } sts_t;

endpackage

### hw/rtl/mcit_ctrl.sv
module mcit_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  mcit_pkg::sts_t sts,
  output mcit_pkg::cmd_t cmd
);
  import mcit_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_STEP = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_TIMERS - 1);

  logic [1:0]       state, state_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic             advance;

  // Next-state and command decode
  always_comb begin
    state_next      = state;
    idx_next        = idx;
    advance         = 1'b0;
    cmd             = '0;
    cmd.idx         = idx;
    s_tready        = (state == S_IDLE) && sts.out_free;
    cmd.accept      = s_tvalid && s_tready;
    case (state)
      S_IDLE: begin
        if (cmd.accept && sts.in_tick) begin
          state_next = S_WALK;
          idx_next   = '0;
        end
      end
      S_WALK: begin
        if (!sts.due) begin
          advance = 1'b1;
        end else if (!sts.filter) begin
          cmd.catch_start = 1'b1;
          state_next      = S_STEP;
        end else if (sts.out_free) begin
          cmd.fire_filter = 1'b1;
          advance         = 1'b1;
        end
      end
      S_STEP: begin
        if (sts.more) begin
          cmd.catch_step = 1'b1;
        end else if (sts.out_free) begin
          cmd.catch_fire = 1'b1;
          advance        = 1'b1;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.done   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    // Move to the next entry or finish the walk
    if (advance) begin
      if (idx == IDX_LAST) begin
        state_next = S_DONE;
      end else begin
        idx_next   = idx + 1'b1;
        state_next = S_WALK;
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  // A result is loaded only when the output register has room
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.fire_filter || cmd.catch_fire || cmd.done) |-> sts.out_free)
    else $error("result loaded into a full output register");

  // An accepted tick starts the walk at entry zero
  a_tick_walk: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && sts.in_tick) |=> (state == S_WALK && idx == '0))
    else $error("tick did not start the walk at entry zero");

  // No input is taken while a tick is in progress
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !cmd.accept)
    else $error("input accepted during a tick");

endmodule

### hw/rtl/mcit_dp.sv
module mcit_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  mcit_pkg::cmd_t                  cmd,
  output mcit_pkg::sts_t                  sts,
  input  logic [mcit_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic [mcit_pkg::OP_W-1:0]       s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [mcit_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic [mcit_pkg::KIND_W-1:0]     m_tuser,
  output logic                            m_tlast
);
  import mcit_pkg::*;

  localparam logic [ID_W:0] ID_LIM = (ID_W + 1)'(NUM_TIMERS);

  // Input fields
  logic [OP_W-1:0]   in_op;
  logic [ID_W-1:0]   in_id;
  logic [TIME_W-1:0] in_now;
  logic [TIME_W-1:0] in_ivl;
  logic              in_mode;
  logic [LIM_W-1:0]  in_extra;
  logic              in_pflag;

  assign in_op    = s_tuser;
  assign in_id    = s_tdata[7:0];
  assign in_now   = s_tdata[39:8];
  assign in_ivl   = s_tdata[71:40];
  assign in_mode  = s_tdata[72];
  assign in_extra = s_tdata[80:73];
  assign in_pflag = s_tdata[81];

  // Timer table
  logic              active [NUM_TIMERS];
  logic              paused [NUM_TIMERS];
  logic [TIME_W-1:0] period [NUM_TIMERS];
  logic [TIME_W-1:0] lf     [NUM_TIMERS];
  logic              filt   [NUM_TIMERS];
  logic [LIM_W-1:0]  lim    [NUM_TIMERS];

  // Tick working registers
  logic [TIME_W-1:0] now_q;
  logic [TIME_W-1:0] wl;
  logic [CNT_W-1:0]  cnt;
  logic [LIM_W-1:0]  k;

  // Output register
  logic [KIND_W-1:0] out_kind;
  logic              out_status;
  logic [FID_W-1:0]  out_id;
  logic [CNT_W-1:0]  out_cnt;
  logic [TIME_W-1:0] out_time;
  logic              out_last;

  logic [IDX_W-1:0]  tid;
  logic              id_ok, id_act, op_fail, op_load, load;
  logic [TIME_W-1:0] el_entry, el_work;

  // Single-entry operation checks
  assign tid    = in_id[IDX_W-1:0];
  assign id_ok  = {1'b0, in_id} < ID_LIM;
  assign id_act = id_ok && active[tid];

  always_comb begin
    case (in_op)
      OP_ARM:         op_fail = !(id_ok && !active[tid]);
      OP_SET_IVL,
      OP_CLEAR,
      OP_RESTART,
      OP_PAUSE:       op_fail = !id_act;
      OP_CLEAR_ALL,
      OP_RESTART_ALL,
      OP_PAUSE_ALL:   op_fail = 1'b0;
      default:        op_fail = 1'b1;
    endcase
  end

  // Due checks for the walked entry, modulo 2^32
  assign el_entry = now_q - lf[cmd.idx];
  assign el_work  = now_q - wl;

  assign sts.in_tick  = (in_op == OP_TICK);
  assign sts.due      = active[cmd.idx] && !paused[cmd.idx] && (el_entry >= period[cmd.idx]);
  assign sts.filter   = filt[cmd.idx];
  assign sts.more     = (k < lim[cmd.idx]) && (el_work >= period[cmd.idx]);
  assign sts.out_free = !m_tvalid || m_tready;

  // Active and pause bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        active[i] <= 1'b0;
        paused[i] <= 1'b0;
      end
    end else if (cmd.accept) begin
      case (in_op)
        OP_ARM: begin
          if (id_ok && !active[tid]) begin
            active[tid] <= 1'b1;
            paused[tid] <= 1'b0;
          end
        end
        OP_CLEAR: begin
          if (id_act) begin
            active[tid] <= 1'b0;
            paused[tid] <= 1'b0;
          end
        end
        OP_CLEAR_ALL: begin
          for (int i = 0; i < NUM_TIMERS; i++) begin
            active[i] <= 1'b0;
            paused[i] <= 1'b0;
          end
        end
        OP_PAUSE: begin
          if (id_act) paused[tid] <= in_pflag;
        end
        OP_PAUSE_ALL: begin
          for (int i = 0; i < NUM_TIMERS; i++) begin
            if (active[i]) paused[i] <= in_pflag;
          end
        end
        default: ;
      endcase
    end
  end

  // Entry payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      case (in_op)
        OP_ARM: begin
          if (id_ok && !active[tid]) begin
            period[tid] <= in_ivl;
            lf[tid]     <= in_now;
            filt[tid]   <= in_mode;
            lim[tid]    <= in_extra;
          end
        end
        OP_SET_IVL: begin
          if (id_act) period[tid] <= in_ivl;
        end
        OP_CLEAR: begin
          if (id_act) begin
            period[tid] <= '0;
            lf[tid]     <= '0;
            filt[tid]   <= 1'b0;
            lim[tid]    <= '0;
          end
        end
        OP_CLEAR_ALL: begin
          for (int i = 0; i < NUM_TIMERS; i++) begin
            period[i] <= '0;
            lf[i]     <= '0;
            filt[i]   <= 1'b0;
            lim[i]    <= '0;
          end
        end
        OP_RESTART: begin
          if (id_act) lf[tid] <= in_now;
        end
        OP_RESTART_ALL: begin
          for (int i = 0; i < NUM_TIMERS; i++) begin
            if (active[i]) lf[i] <= in_now;
          end
        end
        default: ;
      endcase
    end
    if (cmd.fire_filter) lf[cmd.idx] <= now_q;
    if (cmd.catch_fire)  lf[cmd.idx] <= wl;
  end

  // Tick time and catch-up iteration
  always_ff @(posedge clk) begin
    if (cmd.accept) now_q <= in_now;
    if (cmd.catch_start) begin
      wl  <= lf[cmd.idx] + period[cmd.idx];
      cnt <= CNT_W'(1);
      k   <= '0;
    end else if (cmd.catch_step) begin
      wl  <= wl + period[cmd.idx];
      cnt <= cnt + 1'b1;
      k   <= k + 1'b1;
    end
  end

  // Output register
  assign op_load = cmd.accept && !sts.in_tick;
  assign load    = op_load || cmd.fire_filter || cmd.catch_fire || cmd.done;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op_load) begin
      out_kind   <= EV_STATUS;
      out_status <= op_fail;
      out_id     <= '0;
      out_cnt    <= '0;
      out_time   <= '0;
      out_last   <= 1'b1;
    end else if (cmd.fire_filter || cmd.catch_fire) begin
      out_kind   <= EV_FIRE;
      out_status <= 1'b0;
      out_id     <= FID_W'(cmd.idx);
      out_cnt    <= cmd.fire_filter ? CNT_W'(1) : cnt;
      out_time   <= now_q;
      out_last   <= 1'b0;
    end else if (cmd.done) begin
      out_kind   <= EV_DONE;
      out_status <= 1'b0;
      out_id     <= '0;
      out_cnt    <= '0;
      out_time   <= now_q;
      out_last   <= 1'b1;
    end
  end

  assign m_tdata = {2'b00, out_time, out_cnt, out_id, out_status};
  assign m_tuser = out_kind;
  assign m_tlast = out_last;

endmodule

### hw/rtl/multi_channel_interval_timer.sv
// Multi-channel interval timer: a table of NUM_TIMERS periodic timers.
// Input channel s_*: one beat per operation, the code in s_tuser. Output
// channel m_*: result beats, kind in m_tuser, m_tlast on the final beat of
// each operation.
// Arm, set interval, clear, clear all, restart, restart all, pause and pause
// all each return one status beat, loaded into the output register in the
// cycle after the beat is taken. A tick walks the table one entry per cycle,
// except where a due entry waits for the output register or a catch-up
// entry holds the walk while the walk sequencer adds one period per cycle.
// Each due entry gives a fire beat, then a done beat closes the tick.
// The next beat is taken once the tick is finished and the output register
// is free or being drained.
// Reset clears every active and pause bit, which empties the table.
// When the receiver stalls, the result holds in the output register and the
// walk waits at the entry that wants to report.
module multi_channel_interval_timer (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // timer_id[7:0], now[39:8], interval[71:40], hit_mode[72],
  // extra_hits[80:73], pause_flag[81], zero fill
  input  logic [mcit_pkg::IN_DATA_W-1:0]  s_tdata,
  // operation[3:0]
  input  logic [mcit_pkg::OP_W-1:0]       s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // status[0], fired_id[4:1], fire_count[13:5], fire_time[45:14], zero fill
  output logic [mcit_pkg::OUT_DATA_W-1:0] m_tdata,
  // event_kind[1:0]
  output logic [mcit_pkg::KIND_W-1:0]     m_tuser,
  output logic                            m_tlast
);
  import mcit_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  mcit_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Table and result path
  mcit_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

### tb/sv/multi_channel_interval_timer_tb.sv
module multi_channel_interval_timer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mcit_pkg::*;

  // cycles with no beat on either side before the run is abandoned
  localparam int STALL_LIMIT  = 4000;
  // settle time after the last expected beat (one full table walk and then some)
  localparam int DRAIN_CYCLES = NUM_TIMERS + 8;
  localparam int FILL_W       = IN_DATA_W - 82;
  // highest operation code, never assigned
  localparam logic [OP_W-1:0] OP_UNUSED_TOP = 4'hF;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              status;
    logic [FID_W-1:0]  fired_id;
    logic [CNT_W-1:0]  count;
    logic [TIME_W-1:0] fire_time;
    logic              last;
  } timer_beat_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [OP_W-1:0]       s_tuser;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [KIND_W-1:0]     m_tuser;
  logic                  m_tlast;

  // shadow copy of the timer table
  logic              tm_active [NUM_TIMERS];
  logic              tm_paused [NUM_TIMERS];
  logic [TIME_W-1:0] tm_period [NUM_TIMERS];
  logic [TIME_W-1:0] tm_last   [NUM_TIMERS];
  logic              tm_filter [NUM_TIMERS];
  logic [LIM_W-1:0]  tm_limit  [NUM_TIMERS];

  timer_beat_t expected_beats[$];

  int                mismatches   = 0;
  int                burst_left   = 0;
  int                quiet_cycles = 0;
  int                rx_left      = 0;
  logic              rx_open      = 1'b0;
  logic [TIME_W-1:0] clock_now;

  multi_channel_interval_timer DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Apply one request to the shadow table and queue the beats it should produce
  task automatic step_timer_table(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                                  input logic [TIME_W-1:0] t,
                                  input logic [TIME_W-1:0] ivl, input logic mode,
                                  input logic [LIM_W-1:0] extra, input logic pflag);
    timer_beat_t       beat;
    logic [TIME_W-1:0] elapsed;
    logic [CNT_W-1:0]  cnt;
    logic [IDX_W-1:0]  idx;
    logic              id_ok;
    logic              ok;
    int                k;
    id_ok = (id < NUM_TIMERS);
    idx   = id[IDX_W-1:0];
    ok    = 1'b0;
    if (op == OP_TICK) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        elapsed = t - tm_last[i];
        if (tm_active[i] && !tm_paused[i] && elapsed >= tm_period[i]) begin
          cnt = CNT_W'(1);
          if (tm_filter[i]) begin
            tm_last[i] = t;
          end else begin
            // catch-up: one period per fire, bounded by the extra-hit limit
            tm_last[i] = tm_last[i] + tm_period[i];
            k = 0;
            elapsed = t - tm_last[i];
            while (k < tm_limit[i] && elapsed >= tm_period[i]) begin
              cnt++;
              tm_last[i] = tm_last[i] + tm_period[i];
              elapsed = t - tm_last[i];
              k++;
            end
          end
          beat = '{EV_FIRE, 1'b0, FID_W'(i), cnt, t, 1'b0};
          expected_beats.push_back(beat);
        end
      end
      beat = '{EV_DONE, 1'b0, '0, '0, t, 1'b1};
      expected_beats.push_back(beat);
    end else begin
      case (op)
        OP_ARM: begin
          if (id_ok && !tm_active[idx]) begin
            tm_active[idx] = 1'b1;
            tm_paused[idx] = 1'b0;
            tm_period[idx] = ivl;
            tm_last[idx]   = t;
            tm_filter[idx] = mode;
            tm_limit[idx]  = extra;
            ok = 1'b1;
          end
        end
        OP_SET_IVL: begin
          if (id_ok && tm_active[idx]) begin
            tm_period[idx] = ivl;
            ok = 1'b1;
          end
        end
        OP_CLEAR: begin
          if (id_ok && tm_active[idx]) begin
            tm_active[idx] = 1'b0;
            tm_paused[idx] = 1'b0;
            tm_period[idx] = '0;
            tm_last[idx]   = '0;
            tm_filter[idx] = 1'b0;
            tm_limit[idx]  = '0;
            ok = 1'b1;
          end
        end
        OP_CLEAR_ALL: begin
          for (int i = 0; i < NUM_TIMERS; i++) begin
            tm_active[i] = 1'b0;
            tm_paused[i] = 1'b0;
            tm_period[i] = '0;
            tm_last[i]   = '0;
            tm_filter[i] = 1'b0;
            tm_limit[i]  = '0;
          end
          ok = 1'b1;
        end
        OP_RESTART: begin
          if (id_ok && tm_active[idx]) begin
            tm_last[idx] = t;
            ok = 1'b1;
          end
        end
        OP_RESTART_ALL: begin
          for (int i = 0; i < NUM_TIMERS; i++)
            if (tm_active[i]) tm_last[i] = t;
          ok = 1'b1;
        end
        OP_PAUSE: begin
          if (id_ok && tm_active[idx]) begin
            tm_paused[idx] = pflag;
            ok = 1'b1;
          end
        end
        OP_PAUSE_ALL: begin
          for (int i = 0; i < NUM_TIMERS; i++)
            if (tm_active[i]) tm_paused[i] = pflag;
          ok = 1'b1;
        end
        default: ;
      endcase
      beat = '{EV_STATUS, !ok, '0, '0, '0, 1'b1};
      expected_beats.push_back(beat);
    end
  endtask

  // Drive one request beat, in bursts with random gaps between them
  task automatic send_request(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                              input logic [TIME_W-1:0] t, input logic [TIME_W-1:0] ivl,
                              input logic mode, input logic [LIM_W-1:0] extra,
                              input logic pflag);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {{FILL_W{1'b0}}, pflag, extra, mode, ivl, t, id};
    do @(posedge clk); while (!s_tready);
    burst_left--;
    step_timer_table(op, id, t, ivl, mode, extra, pflag);
  endtask

  task automatic compare_field(input string name, input longint want, input longint got);
    if (want != got) begin
      if (mismatches < 10)
        $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $realtime, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_beat();
    timer_beat_t want;
    if (expected_beats.size() == 0) begin
      if (mismatches < 10)
        $display("%0t: unexpected result beat kind %0d data 0x%0h",
                 $realtime, m_tuser, m_tdata);
      mismatches++;
    end else begin
      want = expected_beats.pop_front();
      compare_field("event_kind", 64'(want.kind), 64'(m_tuser));
      compare_field("status", 64'(want.status), 64'(m_tdata[0]));
      compare_field("fired_id", 64'(want.fired_id), 64'(m_tdata[4:1]));
      compare_field("fire_count", 64'(want.count), 64'(m_tdata[13:5]));
      compare_field("fire_time", 64'(want.fire_time), 64'(m_tdata[45:14]));
      compare_field("last", 64'(want.last), 64'(m_tlast));
    end
  endtask

  // Result side: check accepted beats, stall on alternating ready and stall runs
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_beat();
    if (rx_left == 0) begin
      rx_open = !rx_open;
      if (rx_open)
        rx_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      else
        rx_left = $urandom_range(1, 6);
    end else begin
      rx_left--;
    end
    m_tready <= rx_open;
  end

  // Watchdog on beats in either direction
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d beats still expected",
               quiet_cycles, expected_beats.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [ID_W-1:0] pick_id();
    if ($urandom_range(0, 9) == 0) return ID_W'($urandom_range(NUM_TIMERS, 255));
    return ID_W'($urandom_range(0, NUM_TIMERS - 1));
  endfunction

  function automatic logic [TIME_W-1:0] pick_interval();
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return '0;
      default: return $urandom_range(1, 24);
    endcase
  endfunction

  function automatic logic [LIM_W-1:0] pick_extra();
    if ($urandom_range(0, 7) == 0) return LIM_W'($urandom_range(0, 255));
    return LIM_W'($urandom_range(0, 4));
  endfunction

  task automatic test_empty_tick();
    send_request(OP_TICK, 8'd0, 32'd0, 32'd0, 1'b0, 8'd0, 1'b0);
  endtask

  // arm rejects, filter snap, catch-up limit, zero period with the largest limit
  task automatic test_arm_and_fire();
    send_request(OP_ARM, 8'd0, 32'd100, 32'd10, 1'b1, 8'd0, 1'b0);
    send_request(OP_ARM, 8'd0, 32'd100, 32'd10, 1'b1, 8'd0, 1'b0);
    send_request(OP_ARM, 8'd255, 32'd100, 32'd10, 1'b0, 8'd1, 1'b0);
    send_request(OP_ARM, 8'd16, 32'd100, 32'd10, 1'b0, 8'd1, 1'b0);
    send_request(OP_ARM, 8'd15, 32'd100, 32'd0, 1'b0, 8'd255, 1'b0);
    send_request(OP_ARM, 8'd1, 32'd100, 32'd5, 1'b0, 8'd3, 1'b0);
    send_request(OP_TICK, 8'd0, 32'd130, 32'd0, 1'b0, 8'd0, 1'b0);
  endtask

  task automatic test_pause_and_resume();
    send_request(OP_PAUSE, 8'd15, 32'd0, 32'd0, 1'b0, 8'd0, 1'b1);
    send_request(OP_PAUSE, 8'd9, 32'd0, 32'd0, 1'b0, 8'd0, 1'b1);
    send_request(OP_TICK, 8'd0, 32'd200, 32'd0, 1'b0, 8'd0, 1'b0);
    send_request(OP_PAUSE_ALL, 8'd0, 32'd0, 32'd0, 1'b0, 8'd0, 1'b0);
    send_request(OP_TICK, 8'd0, 32'd201, 32'd0, 1'b0, 8'd0, 1'b0);
  endtask

  task automatic test_restart_and_retime();
    send_request(OP_SET_IVL, 8'd1, 32'd0, 32'hFFFF_FFFF, 1'b0, 8'd0, 1'b0);
    send_request(OP_SET_IVL, 8'd7, 32'd0, 32'd4, 1'b0, 8'd0, 1'b0);
    send_request(OP_RESTART, 8'd0, 32'd300, 32'd0, 1'b0, 8'd0, 1'b0);
    send_request(OP_RESTART, 8'd8, 32'd300, 32'd0, 1'b0, 8'd0, 1'b0);
    send_request(OP_RESTART_ALL, 8'd0, 32'hFFFF_FFFF, 32'd0, 1'b0, 8'd0, 1'b0);
    send_request(OP_TICK, 8'd0, 32'hFFFF_FFFF, 32'd0, 1'b0, 8'd0, 1'b0);
  endtask

  task automatic test_clear();
    send_request(OP_CLEAR, 8'd15, 32'd0, 32'd0, 1'b0, 8'd0, 1'b0);
    send_request(OP_CLEAR, 8'd15, 32'd0, 32'd0, 1'b0, 8'd0, 1'b0);
    send_request(OP_CLEAR_ALL, 8'd0, 32'd0, 32'd0, 1'b0, 8'd0, 1'b0);
  endtask

  task automatic test_bad_codes();
    send_request(OP_PAUSE_ALL + 4'd1, 8'd0, 32'd0, 32'd0, 1'b0, 8'd0, 1'b0);
    send_request(OP_UNUSED_TOP, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 8'hFF, 1'b1);
  endtask

  // elapsed time computed across the 32-bit wrap
  task automatic test_wraparound();
    send_request(OP_ARM, 8'd2, 32'hFFFF_FFF0, 32'h20, 1'b0, 8'd2, 1'b0);
    send_request(OP_TICK, 8'd0, 32'h0000_0050, 32'd0, 1'b0, 8'd0, 1'b0);
  endtask

  // Mostly coherent schedules: a running clock, valid ids, short periods
  task automatic test_random_schedule();
    int                r;
    logic [ID_W-1:0]   rid;
    logic [TIME_W-1:0] rt;
    logic [TIME_W-1:0] rivl;
    logic              rmode;
    logic [LIM_W-1:0]  rext;
    logic              rpflag;
    repeat (440) begin
      r      = $urandom_range(0, 99);
      rid    = ID_W'($urandom);
      rt     = $urandom;
      rivl   = $urandom;
      rmode  = 1'($urandom);
      rext   = LIM_W'($urandom);
      rpflag = 1'($urandom);
      if (r < 40) begin
        clock_now += ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 12);
        send_request(OP_TICK, rid, clock_now, rivl, rmode, rext, rpflag);
      end else if (r < 58) begin
        send_request(OP_ARM, pick_id(), clock_now, pick_interval(), rmode, pick_extra(),
                     rpflag);
      end else if (r < 66) begin
        send_request(OP_SET_IVL, pick_id(), rt, pick_interval(), rmode, rext, rpflag);
      end else if (r < 72) begin
        send_request(OP_CLEAR, pick_id(), rt, rivl, rmode, rext, rpflag);
      end else if (r < 74) begin
        send_request(OP_CLEAR_ALL, rid, rt, rivl, rmode, rext, rpflag);
      end else if (r < 80) begin
        send_request(OP_RESTART, pick_id(), clock_now, rivl, rmode, rext, rpflag);
      end else if (r < 83) begin
        send_request(OP_RESTART_ALL, rid, clock_now, rivl, rmode, rext, rpflag);
      end else if (r < 91) begin
        send_request(OP_PAUSE, pick_id(), rt, rivl, rmode, rext, rpflag);
      end else if (r < 96) begin
        send_request(OP_PAUSE_ALL, rid, rt, rivl, rmode, rext,
                     ($urandom_range(0, 2) == 0));
      end else begin
        send_request(OP_TICK, rid, rt, rivl, rmode, rext, rpflag);
      end
    end
  endtask

  // Any code, any field value, including unknown operations
  task automatic test_random_noise();
    repeat (60)
      send_request(OP_W'($urandom_range(0, 15)), ID_W'($urandom), $urandom, $urandom,
                   1'($urandom), LIM_W'($urandom), 1'($urandom));
  endtask

  initial begin
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= OP_TICK;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      tm_active[i] = 1'b0;
      tm_paused[i] = 1'b0;
      tm_period[i] = '0;
      tm_last[i]   = '0;
      tm_filter[i] = 1'b0;
      tm_limit[i]  = '0;
    end
    clock_now = $urandom;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_empty_tick();
    test_arm_and_fire();
    test_pause_and_resume();
    test_restart_and_retime();
    test_clear();
    test_bad_codes();
    test_wraparound();
    test_random_schedule();
    test_random_noise();

    s_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
